// ===== rtl/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Overlapping implication checked on every rising edge outside reset.
`define RSSD_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication checked on every rising edge outside reset.
`define RSSD_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/rssd_pkg.sv =====
`timescale 1ns / 1ps
package rssd_pkg;

  localparam int unsigned SampleBits = 16;
  localparam int unsigned MeanBits   = SampleBits + 32;
  localparam int unsigned GroupBits  = 4;
  localparam int unsigned CountBits  = 32;
  localparam int unsigned SumBits    = 64;
  localparam int unsigned WideBits   = 64;
  localparam int unsigned StdBits    = 32;

  localparam logic MODE_UPDATE   = 1'b0;
  localparam logic MODE_FINALIZE = 1'b1;

  typedef struct packed {
    logic                         mode;
    logic [GroupBits-1:0]         group;
    logic signed [SampleBits-1:0] sample;
    logic                         sample_null;
  } in_item_t;

  typedef struct packed {
    logic [GroupBits-1:0] group_out;
    logic [StdBits-1:0]   std_dev;
    logic                 result_null;
  } out_item_t;

  typedef struct packed {
    logic       capture;
    logic       div_init;
    logic       div_step;
    logic       mean_calc;
    logic       mul_step;
    logic [2:0] mul_idx;
    logic       write_back;
    logic       sqrt_init;
    logic       sqrt_step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic is_update;
    logic skip;
    logic short_fin;
    logic out_busy;
  } status_t;

endpackage

// ===== rtl/running_sample_stddev_core.sv =====
`timescale 1ns / 1ps
// Per-group sample standard deviation by Welford's method. An update item runs
// the 64-step restoring divider, and a finalize item runs it and then the 32-step
// square root; both are skipped for a finalize when the group holds fewer than two
// samples and for an update of a null sample or unknown group. The divider is shared
// by the mean step and the final quotient. Items are handled one at a time; a finished
// result waits in the output register while the next item is accepted.
module running_sample_stddev_core
  import rssd_pkg::*;
#(
  parameter int unsigned GROUPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_item_o
);

  cmd_t    cmd;
  status_t status;

  rssd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  rssd_datapath #(
    .GROUPS (GROUPS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (in_item_i),
    .cmd_i       (cmd),
    .status_o    (status),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .out_item_o  (out_item_o)
  );

endmodule

// ===== rtl/rssd_ctrl.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rssd_ctrl
  import rssd_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_PREP  = 9'b000000010,
    ST_DIV   = 9'b000000100,
    ST_MEAN  = 9'b000001000,
    ST_MUL   = 9'b000010000,
    ST_SUM   = 9'b000100000,
    ST_ROOTI = 9'b001000000,
    ST_ROOT  = 9'b010000000,
    ST_FOUT  = 9'b100000000
  } state_e;

  state_e     state_q, state_d;
  logic [5:0] cnt_q, cnt_d;

  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = ST_PREP;
        end
      end
      ST_PREP: begin
        cnt_d = '0;
        if (status_i.skip) begin
          state_d = ST_IDLE;
        end else if (status_i.short_fin) begin
          state_d = ST_FOUT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 6'd1;
        if (&cnt_q) begin
          state_d = status_i.is_update ? ST_MEAN : ST_ROOTI;
        end
      end
      ST_MEAN: begin
        cmd_o.mean_calc = 1'b1;
        cnt_d           = '0;
        state_d         = ST_MUL;
      end
      ST_MUL: begin
        cmd_o.mul_step = 1'b1;
        cmd_o.mul_idx  = cnt_q[2:0];
        cnt_d          = cnt_q + 6'd1;
        if (cnt_q[2:0] == 3'd4) begin
          state_d = ST_SUM;
        end
      end
      ST_SUM: begin
        cmd_o.write_back = 1'b1;
        state_d          = ST_IDLE;
      end
      ST_ROOTI: begin
        cmd_o.sqrt_init = 1'b1;
        cnt_d           = '0;
        state_d         = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.sqrt_step = 1'b1;
        cnt_d           = cnt_q + 6'd1;
        if (cnt_q == 6'd31) begin
          state_d = ST_FOUT;
        end
      end
      ST_FOUT: begin
        if (!status_i.out_busy) begin
          cmd_o.out_load = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  `RSSD_ASSERT_NXT(a_accept_prep, clk_i, rst_ni, in_valid_i && in_ready_o, state_q == ST_PREP)
  `RSSD_ASSERT_IMP(a_load_free, clk_i, rst_ni, cmd_o.out_load, !status_i.out_busy)
  `RSSD_ASSERT_IMP(a_mul_range, clk_i, rst_ni, state_q == ST_MUL, cnt_q <= 6'd4)

endmodule

// ===== rtl/rssd_datapath.sv =====
`timescale 1ns / 1ps
`include "assert_macros.svh"
module rssd_datapath
  import rssd_pkg::*;
#(
  parameter int unsigned GROUPS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  in_item_t  item_i,
  input  cmd_t      cmd_i,
  output status_t   status_o,
  input  logic      out_ready_i,
  output logic      out_valid_o,
  output out_item_t out_item_o
);

  localparam int unsigned Depth = (GROUPS < (1 << GroupBits)) ? GROUPS : (1 << GroupBits);
  localparam int unsigned Iw    = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned Ext   = WideBits - SampleBits - 32;
  localparam int unsigned MExt  = WideBits - MeanBits;

  logic [CountBits-1:0] cnt_q  [Depth];
  logic [MeanBits-1:0]  mean_q [Depth];
  logic [SumBits-1:0]   sum_q  [Depth];

  in_item_t              item_q;
  logic [WideBits-1:0]   dvd_q, ma_q, mb_q, v_q;
  logic [31:0]           dvs_q, rem_q, root_q;
  logic                  neg_q, mix_q, ovf_q;
  logic [MeanBits-1:0]   nm_q;
  logic [63:0]           pp_q;
  logic [1:0]            psh_q;
  logic [127:0]          acc_q;
  logic [33:0]           rrem_q;
  out_item_t             out_q;
  logic                  out_valid_q;

  logic                  grp_ok;
  logic [Iw-1:0]         idx;
  logic [CountBits-1:0]  rd_cnt, new_cnt;
  logic [MeanBits-1:0]   rd_mean, nm;
  logic [SumBits-1:0]    rd_sum, inc, sum_new;
  logic [SumBits:0]      sum_ext;
  logic [WideBits-1:0]   xu, m64, d_old, d_old_mag, delta, d_new;
  logic [32:0]           dtrial;
  logic [35:0]           rr, rtrial;
  logic [31:0]           mul_a, mul_b;
  logic [127:0]          pp_sh;

  assign grp_ok  = (32'(item_q.group) < GROUPS);
  assign idx     = grp_ok ? item_q.group[Iw-1:0] : '0;
  assign rd_cnt  = cnt_q[idx];
  assign rd_mean = mean_q[idx];
  assign rd_sum  = sum_q[idx];
  assign new_cnt = (&rd_cnt) ? rd_cnt : rd_cnt + 32'd1;

  assign xu        = {{Ext{item_q.sample[SampleBits-1]}}, item_q.sample, 32'b0};
  assign m64       = {{MExt{rd_mean[MeanBits-1]}}, rd_mean};
  assign d_old     = xu - m64;
  assign d_old_mag = d_old[WideBits-1] ? (~d_old + 64'd1) : d_old;
  assign delta     = neg_q ? (~dvd_q + 64'd1) : dvd_q;
  assign nm        = MeanBits'(m64 + delta);
  assign d_new     = xu - {{MExt{nm[MeanBits-1]}}, nm};

  assign dtrial = {rem_q, dvd_q[WideBits-1]};
  assign rr     = {rrem_q, v_q[63:62]};
  assign rtrial = {2'b00, root_q, 2'b01};

  assign mul_a = cmd_i.mul_idx[1] ? ma_q[63:32] : ma_q[31:0];
  assign mul_b = cmd_i.mul_idx[0] ? mb_q[63:32] : mb_q[31:0];

  always_comb begin
    case (psh_q)
      2'd0:    pp_sh = {64'b0, pp_q};
      2'd1:    pp_sh = {32'b0, pp_q, 32'b0};
      default: pp_sh = {pp_q, 64'b0};
    endcase
  end

  assign inc     = mix_q ? '0 : ((|acc_q[127:112]) ? '1 : acc_q[111:48]);
  assign sum_ext = {1'b0, rd_sum} + {1'b0, inc};
  assign sum_new = sum_ext[SumBits] ? '1 : sum_ext[SumBits-1:0];

  assign status_o.is_update = (item_q.mode == MODE_UPDATE);
  assign status_o.skip      = (item_q.mode == MODE_UPDATE) && (item_q.sample_null || !grp_ok);
  assign status_o.short_fin = (item_q.mode == MODE_FINALIZE) &&
                              (!grp_ok || rd_cnt <= 32'd1);
  assign status_o.out_busy  = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      item_q <= item_i;
    end
    if (cmd_i.div_init) begin
      rem_q <= '0;
      if (item_q.mode == MODE_UPDATE) begin
        dvd_q <= d_old_mag;
        dvs_q <= new_cnt;
        neg_q <= d_old[WideBits-1];
      end else begin
        dvd_q <= rd_sum;
        dvs_q <= rd_cnt - 32'd1;
        neg_q <= 1'b0;
      end
    end else if (cmd_i.div_step) begin
      if (dtrial >= {1'b0, dvs_q}) begin
        rem_q <= 32'(dtrial - {1'b0, dvs_q});
        dvd_q <= {dvd_q[WideBits-2:0], 1'b1};
      end else begin
        rem_q <= dtrial[31:0];
        dvd_q <= {dvd_q[WideBits-2:0], 1'b0};
      end
    end
    if (cmd_i.mean_calc) begin
      nm_q  <= nm;
      ma_q  <= d_old_mag;
      mb_q  <= d_new[WideBits-1] ? (~d_new + 64'd1) : d_new;
      mix_q <= (d_old[WideBits-1] != d_new[WideBits-1]) && (d_old != '0) && (d_new != '0);
      acc_q <= '0;
    end else if (cmd_i.mul_step) begin
      pp_q  <= 64'(mul_a) * 64'(mul_b);
      psh_q <= 2'(cmd_i.mul_idx[1]) + 2'(cmd_i.mul_idx[0]);
      if (cmd_i.mul_idx != 3'd0) begin
        acc_q <= acc_q + pp_sh;
      end
    end
    if (cmd_i.sqrt_init) begin
      v_q    <= {dvd_q[47:0], 16'b0};
      ovf_q  <= |dvd_q[63:48];
      rrem_q <= '0;
      root_q <= '0;
    end else if (cmd_i.sqrt_step) begin
      v_q <= {v_q[61:0], 2'b00};
      if (rr >= rtrial) begin
        rrem_q <= 34'(rr - rtrial);
        root_q <= {root_q[30:0], 1'b1};
      end else begin
        rrem_q <= rr[33:0];
        root_q <= {root_q[30:0], 1'b0};
      end
    end
    if (cmd_i.out_load) begin
      out_q.group_out <= item_q.group;
      if (status_o.short_fin) begin
        out_q.result_null <= !grp_ok || (rd_cnt == '0);
        out_q.std_dev     <= '0;
      end else begin
        out_q.result_null <= 1'b0;
        out_q.std_dev     <= ovf_q ? '1 : root_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      for (int i = 0; i < Depth; i++) begin
        cnt_q[i]  <= '0;
        mean_q[i] <= '0;
        sum_q[i]  <= '0;
      end
    end else begin
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cmd_i.write_back) begin
        cnt_q[idx]  <= new_cnt;
        mean_q[idx] <= nm_q;
        sum_q[idx]  <= sum_new;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  `RSSD_ASSERT_IMP(a_null_zero, clk_i, rst_ni, out_valid_o && out_item_o.result_null, out_item_o.std_dev == '0)

endmodule

// ===== bench/stddev_checker.sv =====
`timescale 1ns / 1ps
module stddev_checker
  import rssd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_ready_i,
  input  in_item_t    in_item_i,
  input  logic        out_valid_i,
  input  logic        out_ready_i,
  input  out_item_t   out_item_i,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned update_count_o,
  output int unsigned finalize_count_o
);

  logic [CountBits-1:0]       grp_count [16];
  logic signed [MeanBits-1:0] grp_mean  [16];
  logic [SumBits-1:0]         grp_sqsum [16];
  out_item_t                  deviation_queue[$];

  function automatic logic [63:0] floor_sqrt(input logic [63:0] v);
    logic [63:0] res;
    logic [63:0] bitv;
    res  = '0;
    bitv = 64'd1 << 62;
    while (bitv > v) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (v >= res + bitv) begin
        v   = v - (res + bitv);
        res = (res >> 1) + bitv;
      end else begin
        res = res >> 1;
      end
      bitv = bitv >> 2;
    end
    return res;
  endfunction

  function automatic logic [63:0] mag(input logic signed [63:0] v);
    return v[63] ? -v : v;
  endfunction

  task automatic welford_update(input in_item_t it);
    int g;
    logic signed [63:0] xu, d_old, d_new, delta, old_mean;
    logic signed [MeanBits-1:0] mean_next;
    logic [127:0] prod;
    logic [63:0] inc;
    logic [64:0] total;
    g = it.group;
    if (it.sample_null) return;
    if (grp_count[g] != '1) grp_count[g] = grp_count[g] + 1;
    xu        = 64'(signed'(it.sample)) <<< 32;
    old_mean  = 64'(grp_mean[g]);
    d_old     = xu - old_mean;
    delta     = d_old / $signed({32'd0, grp_count[g]});
    mean_next = MeanBits'(old_mean + delta);
    d_new     = xu - 64'(mean_next);
    if ((d_old[63] != d_new[63]) && d_old != 0 && d_new != 0) begin
      inc = '0;
    end else begin
      prod = 128'(mag(d_old)) * 128'(mag(d_new));
      inc  = (prod[127:112] != 0) ? '1 : prod[111:48];
    end
    total        = {1'b0, grp_sqsum[g]} + {1'b0, inc};
    grp_sqsum[g] = total[64] ? '1 : total[63:0];
    grp_mean[g]  = mean_next;
  endtask

  function automatic out_item_t deviation_of(input in_item_t it);
    out_item_t r;
    logic [63:0] q;
    int g;
    g = it.group;
    r.group_out   = it.group;
    r.std_dev     = '0;
    r.result_null = 1'b0;
    if (grp_count[g] == 0) begin
      r.result_null = 1'b1;
    end else if (grp_count[g] > 1) begin
      q = grp_sqsum[g] / {32'd0, grp_count[g] - 32'd1};
      if (q[63:48] != 0) r.std_dev = '1;
      else r.std_dev = 32'(floor_sqrt(q << 16));
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_item_t   want;
    int unsigned errs;
    errs = 0;
    if (!rst_ni) begin
      for (int g = 0; g < 16; g++) begin
        grp_count[g] = '0;
        grp_mean[g]  = '0;
        grp_sqsum[g] = '0;
      end
      deviation_queue.delete();
      fail_count_o     <= 0;
      pending_o        <= 0;
      update_count_o   <= 0;
      finalize_count_o <= 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (deviation_queue.size() == 0) begin
          $error("unexpected result item for group %0d", out_item_i.group_out);
          errs = errs + 1;
        end else begin
          want = deviation_queue.pop_front();
          if (want.group_out !== out_item_i.group_out) begin
            $error("group_out: expected %0d, got %0d", want.group_out, out_item_i.group_out);
            errs = errs + 1;
          end
          if (want.std_dev !== out_item_i.std_dev) begin
            $error("std_dev: expected %h, got %h", want.std_dev, out_item_i.std_dev);
            errs = errs + 1;
          end
          if (want.result_null !== out_item_i.result_null) begin
            $error("result_null: expected %0d, got %0d", want.result_null,
                   out_item_i.result_null);
            errs = errs + 1;
          end
        end
      end
      if (in_valid_i && in_ready_i) begin
        if (in_item_i.mode == MODE_FINALIZE) begin
          deviation_queue.push_back(deviation_of(in_item_i));
          finalize_count_o <= finalize_count_o + 1;
        end else begin
          welford_update(in_item_i);
          update_count_o <= update_count_o + 1;
        end
      end
      fail_count_o <= fail_count_o + errs;
      pending_o    <= unsigned'(deviation_queue.size());
    end
  end

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 1ps
module testbench;
  import rssd_pkg::*;

  localparam int unsigned WatchdogLimit = 20000;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_item;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_item;
  int unsigned fail_count;
  int unsigned pending;
  int unsigned updates;
  int unsigned finalizes;
  logic        steady;
  int unsigned quiet_cycles;

  running_sample_stddev_core dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_item_o  (out_item)
  );

  stddev_checker u_checker (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .in_valid_i       (in_valid),
    .in_ready_i       (in_ready),
    .in_item_i        (in_item),
    .out_valid_i      (out_valid),
    .out_ready_i      (out_ready),
    .out_item_i       (out_item),
    .fail_count_o     (fail_count),
    .pending_o        (pending),
    .update_count_o   (updates),
    .finalize_count_o (finalizes)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) out_ready <= 1'b0;
    else out_ready <= steady || ($urandom_range(99) >= 11);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic send_item(input logic mode, input int grp, input int smp, input logic nul);
    if (!steady) begin
      while ($urandom_range(99) < 11) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid          <= 1'b1;
    in_item.mode        <= mode;
    in_item.group       <= 4'(grp);
    in_item.sample      <= 16'(smp);
    in_item.sample_null <= nul;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic random_item(input int span);
    int grp;
    grp = $urandom_range(span);
    if ($urandom_range(99) < 20)
      send_item(MODE_FINALIZE, grp, $urandom, 1'($urandom_range(1)));
    else if ($urandom_range(99) < 5)
      send_item(MODE_UPDATE, grp, $urandom, 1'b1);
    else if ($urandom_range(3) == 0)
      send_item(MODE_UPDATE, grp, $urandom_range(1) ? 32767 : -32768, 1'b0);
    else
      send_item(MODE_UPDATE, grp, $urandom, 1'b0);
  endtask

  initial begin
    rst_n    = 1'b0;
    in_valid = 1'b0;
    in_item  = '0;
    steady   = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(MODE_FINALIZE, 0, 0, 1'b0);
    send_item(MODE_UPDATE, 0, 1234, 1'b1);
    send_item(MODE_FINALIZE, 0, 0, 1'b0);
    send_item(MODE_UPDATE, 0, -32768, 1'b0);
    send_item(MODE_FINALIZE, 0, 0, 1'b0);
    send_item(MODE_UPDATE, 0, 32767, 1'b0);
    send_item(MODE_FINALIZE, 0, 0, 1'b0);
    send_item(MODE_UPDATE, 15, 32767, 1'b0);
    send_item(MODE_UPDATE, 15, 32767, 1'b0);
    send_item(MODE_FINALIZE, 15, -1, 1'b1);
    send_item(MODE_UPDATE, 7, -1, 1'b0);
    send_item(MODE_UPDATE, 7, 0, 1'b0);
    send_item(MODE_UPDATE, 7, 1, 1'b0);
    send_item(MODE_FINALIZE, 7, 0, 1'b0);
    send_item(MODE_FINALIZE, 3, 0, 1'b0);
    for (int i = 0; i < 6; i++)
      send_item(MODE_UPDATE, 0, (i % 2) ? 32767 : -32768, 1'b0);
    send_item(MODE_FINALIZE, 0, 0, 1'b0);

    for (int i = 0; i < 1000; i++) begin
      steady <= (i >= 400 && i < 550);
      random_item((i < 700) ? 3 : 15);
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    $display("Ran %0d update and %0d finalize items over all groups,", updates, finalizes);
    $display("with extreme and null samples, empty groups and random stalls.");
    if (fail_count == 0) $display("Testbench completed without errors");
    else $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
